// ----- rtl/scfs_pkg.sv -----
// Package for the separation coil fire sequencer.
// Holds the coil order table, the register index codes and the shared types.
// No dependencies.
`timescale 1ns / 1ps

package scfs_pkg;

  localparam int unsigned NUM_COILS   = 4;
  localparam int unsigned COIL_W      = 2;
  localparam int unsigned ORDER_W     = 5;
  localparam int unsigned GAP_W       = 8;
  localparam int unsigned LIMIT_W     = 15;
  localparam int unsigned REQ_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned ORDER_COUNT = 24;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd200;

  // Register indexes of the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRE_ORDER    = 3'd0,
    REG_GAP_FIRST     = 3'd1,
    REG_GAP_SECOND    = 3'd2,
    REG_GAP_THIRD     = 3'd3,
    REG_REQUEST_LIMIT = 3'd4
  } scfs_reg_e;

  // Coil order table: the coil at position p sits in bits [2p+1:2p].
  // Entries follow the lexicographic order of the coil sequences.
  localparam logic [7:0] ORDER_TABLE [ORDER_COUNT] = '{
    8'b11_10_01_00, 8'b10_11_01_00, 8'b11_01_10_00, 8'b01_11_10_00,
    8'b10_01_11_00, 8'b01_10_11_00, 8'b11_10_00_01, 8'b10_11_00_01,
    8'b11_00_10_01, 8'b00_11_10_01, 8'b10_00_11_01, 8'b00_10_11_01,
    8'b11_01_00_10, 8'b01_11_00_10, 8'b11_00_01_10, 8'b00_11_01_10,
    8'b01_00_11_10, 8'b00_01_11_10, 8'b10_01_00_11, 8'b01_10_00_11,
    8'b10_00_01_11, 8'b00_10_01_11, 8'b01_00_10_11, 8'b00_01_10_11
  };

  // Settings as held in the configuration registers
  typedef struct packed {
    logic [ORDER_W-1:0] fire_order;
    logic [GAP_W-1:0]   gap_first;
    logic [GAP_W-1:0]   gap_second;
    logic [GAP_W-1:0]   gap_third;
    logic [LIMIT_W-1:0] request_limit;
  } scfs_cfg_t;

  // All coils fired by one input item, in firing order
  typedef struct packed {
    logic [NUM_COILS-1:0][COIL_W-1:0] coil;
    logic [NUM_COILS-1:0]             sep;
    logic [COUNT_W-1:0]               count;
  } scfs_burst_t;

  // Coil switched on at a position of a valid order
  function automatic logic [COIL_W-1:0] coil_at(input logic [ORDER_W-1:0] order,
                                                 input logic [1:0] pos);
    logic [7:0] entry;
    entry = ORDER_TABLE[order];
    return entry[{pos, 1'b0} +: COIL_W];
  endfunction

endpackage

// ----- rtl/scfs_if.sv -----
// Channel interfaces of the separation coil fire sequencer.
// Depends on scfs_pkg for field widths.
`timescale 1ns / 1ps

// Input items: ticks and start requests
interface scfs_item_if import scfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [REQ_W-1:0] request_value;

  modport source (output valid, output action, output request_value, input ready);
  modport sink   (input valid, input action, input request_value, output ready);
endinterface

// Result items: one per coil switched on
interface scfs_result_if import scfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COIL_W-1:0] coil_number;
  logic              last_of_run;
  logic              separated;

  modport source (output valid, output coil_number, output last_of_run,
                  output separated, input ready);
  modport sink   (input valid, input coil_number, input last_of_run,
                  input separated, output ready);
endinterface

// Configuration register writes
interface scfs_cfg_if import scfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/separation_coil_fire_sequencer.sv -----
// Separation coil fire sequencer: configuration registers, sequencing state
// and result stage. Depends on scfs_pkg, scfs_if, scfs_seq and scfs_burst.
`timescale 1ns / 1ps

// Fires four separation coils in one of 24 orders. Start requests and 1 ms
// ticks come in on the item channel; each coil switched on leaves as one
// result transfer, the last one caused by an item carrying last_of_run.
// The decision for an item is made in the cycle it is accepted, so items
// are taken one per cycle while the result stage is free. An item that
// fires k coils holds the result stage for its k transfers (k up to 4), and the
// next item is taken in the cycle its last result transfers. Items that fire
// nothing never wait on the result side beyond a held burst. Configuration
// writes are always taken and must only happen while the block is idle.

module separation_coil_fire_sequencer import scfs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  scfs_item_if.sink      item_i,
  scfs_cfg_if.sink       cfg_i,
  scfs_result_if.source  result_o
);

  scfs_cfg_t   cfg_q;
  scfs_burst_t burst;
  logic        load;
  logic        can_load;
  logic        accept;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = can_load;
  assign accept       = item_i.valid && can_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fire_order    <= '0;
      cfg_q.gap_first     <= '0;
      cfg_q.gap_second    <= '0;
      cfg_q.gap_third     <= '0;
      cfg_q.request_limit <= LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FIRE_ORDER:    cfg_q.fire_order    <= cfg_i.data[ORDER_W-1:0];
        REG_GAP_FIRST:     cfg_q.gap_first     <= cfg_i.data[GAP_W-1:0];
        REG_GAP_SECOND:    cfg_q.gap_second    <= cfg_i.data[GAP_W-1:0];
        REG_GAP_THIRD:     cfg_q.gap_third     <= cfg_i.data[GAP_W-1:0];
        REG_REQUEST_LIMIT: cfg_q.request_limit <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  scfs_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .accept_i        (accept),
    .action_i        (item_i.action),
    .request_value_i (item_i.request_value),
    .load_o          (load),
    .burst_o         (burst)
  );

  scfs_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .burst_i    (burst),
    .can_load_o (can_load),
    .result_o   (result_o)
  );

endmodule

// ----- rtl/scfs_seq.sv -----
// Sequencing state of the coil firing: step, gap counter and separated flag.
// Decides per accepted item which coils fire. Depends on scfs_pkg.
`timescale 1ns / 1ps

module scfs_seq import scfs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scfs_cfg_t               cfg_i,
  input  logic                    accept_i,
  input  logic                    action_i,
  input  logic signed [REQ_W-1:0] request_value_i,
  output logic                    load_o,
  output scfs_burst_t             burst_o
);

  logic [1:0]       step_q, step_d;
  logic [GAP_W-1:0] gap_cnt_q, gap_cnt_d;
  logic             sep_q, sep_d;

  // Start check, tick countdown, then cascade through zero gaps
  always_comb begin
    logic             fire;
    logic             active;
    logic [1:0]       p0;
    logic [1:0]       pos_v;
    logic [COUNT_W-1:0] n;
    logic [GAP_W-1:0] g;
    step_d    = step_q;
    gap_cnt_d = gap_cnt_q;
    sep_d     = sep_q;
    burst_o   = '0;
    fire      = 1'b0;
    active    = 1'b1;
    p0        = 2'd0;
    n         = '0;
    g         = '0;
    pos_v     = 2'd0;
    if (accept_i) begin
      if (action_i) begin
        if (step_q == 2'd0 && !request_value_i[REQ_W-1] &&
            cfg_i.request_limit != '0 &&
            request_value_i[LIMIT_W-1:0] < cfg_i.request_limit) begin
          fire = 1'b1;
        end
      end else if (step_q != 2'd0) begin
        if (gap_cnt_q <= 8'd1) begin
          gap_cnt_d = '0;
          fire      = 1'b1;
          p0        = step_q;
        end else begin
          gap_cnt_d = gap_cnt_q - 8'd1;
        end
      end
    end
    if (fire) begin
      for (int pos = 0; pos < NUM_COILS; pos++) begin
        pos_v = 2'(pos);
        if (active && pos_v >= p0) begin
          if (pos_v == 2'd3) begin
            sep_d = 1'b1;
          end
          if (cfg_i.fire_order < ORDER_W'(ORDER_COUNT)) begin
            burst_o.coil[n[1:0]] = coil_at(cfg_i.fire_order, pos_v);
            burst_o.sep[n[1:0]]  = sep_d;
            n = n + 3'd1;
          end
          if (pos_v == 2'd3) begin
            step_d    = 2'd0;
            gap_cnt_d = '0;
            active    = 1'b0;
          end else begin
            unique case (pos_v)
              2'd0:    g = cfg_i.gap_first;
              2'd1:    g = cfg_i.gap_second;
              default: g = cfg_i.gap_third;
            endcase
            if (g != '0) begin
              active    = 1'b0;
              gap_cnt_d = g;
              step_d    = pos_v + 2'd1;
            end
          end
        end
      end
    end
    burst_o.count = n;
    load_o        = fire && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= 2'd0;
      gap_cnt_q <= '0;
      sep_q     <= 1'b0;
    end else begin
      step_q    <= step_d;
      gap_cnt_q <= gap_cnt_d;
      sep_q     <= sep_d;
    end
  end

endmodule

// ----- rtl/scfs_burst.sv -----
// Result stage: holds the coils fired by one item and hands them out one
// transfer at a time. Depends on scfs_pkg and scfs_if.
`timescale 1ns / 1ps

module scfs_burst import scfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  scfs_burst_t  burst_i,
  output logic         can_load_o,
  scfs_result_if.source result_o
);

  logic        valid_q, valid_d;
  scfs_burst_t burst_q, burst_d;
  logic [1:0]  idx_q, idx_d;
  logic        last;
  logic        take;

  assign last = ({1'b0, idx_q} == (burst_q.count - 3'd1));
  assign take = valid_q && result_o.ready;
  assign can_load_o = !valid_q || (result_o.ready && last);

  assign result_o.valid       = valid_q;
  assign result_o.coil_number = burst_q.coil[idx_q];
  assign result_o.last_of_run = last;
  assign result_o.separated   = burst_q.sep[idx_q];

  // Load a new burst or step through the current one
  always_comb begin
    valid_d = valid_q;
    burst_d = burst_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      burst_d = burst_i;
      idx_d   = 2'd0;
    end else if (take) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

endmodule
